FILE: rtl/pnsh_pkg.sv
// package for the point-near-segment hit test
// widths and stream packing shared by the top level and the divider pipeline
`default_nettype none
package pnsh_pkg;
  localparam int COORD_BITS = 16;
  localparam int TOL_BITS   = 10;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int LEN_W      = PROD_W;
  localparam int AC_W       = SUM_W;
  localparam int AL_W       = AC_W / 2;
  localparam int AH_W       = AC_W - AL_W;
  localparam int SQ_W       = 2 * AC_W;
  localparam int TOL2_W     = 2 * TOL_BITS;
  localparam int TL_W       = TOL2_W + LEN_W;
  localparam int CMP_W      = (SQ_W > TL_W) ? SQ_W : TL_W;
  localparam int NUM_W      = COORD_BITS + LEN_W;
  localparam int FOOT_W     = COORD_BITS + 2;
  localparam int IN_W       = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8;
endpackage
`default_nettype wire

FILE: rtl/pnsh_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on pnsh_pkg; quotient must fit in COORD_BITS bits
`default_nettype none
module pnsh_div (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [pnsh_pkg::NUM_W-1:0]       num_i,
  input  wire logic [pnsh_pkg::LEN_W-1:0]       den_i,
  output logic      [pnsh_pkg::COORD_BITS-1:0]  q_o,
  output logic                                  rnz_o
);
  import pnsh_pkg::*;

  logic [LEN_W-1:0]      r_r   [COORD_BITS];
  logic [COORD_BITS-1:0] q_r   [COORD_BITS];
  logic [COORD_BITS-1:0] lo_r  [COORD_BITS];
  logic [LEN_W-1:0]      den_r [COORD_BITS];

  for (genvar i = 0; i < COORD_BITS; i++) begin : g_stage
    logic [LEN_W-1:0]      rin;
    logic [COORD_BITS-1:0] qin;
    logic [COORD_BITS-1:0] loin;
    logic [LEN_W-1:0]      denin;
    logic [LEN_W:0]        t;
    logic                  ge;
    logic [LEN_W-1:0]      r_nxt;

    if (i == 0) begin : g_first
      // upper bits of the numerator are already below the divisor
      assign rin   = num_i[NUM_W-1 -: LEN_W];
      assign qin   = '0;
      assign loin  = num_i[COORD_BITS-1:0];
      assign denin = den_i;
    end else begin : g_next
      assign rin   = r_r[i-1];
      assign qin   = q_r[i-1];
      assign loin  = lo_r[i-1];
      assign denin = den_r[i-1];
    end

    always_comb begin
      t     = {rin, loin[COORD_BITS-1]};
      ge    = (t >= {1'b0, denin});
      r_nxt = ge ? LEN_W'(t - {1'b0, denin}) : t[LEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]   <= r_nxt;
        q_r[i]   <= {qin[COORD_BITS-2:0], ge};
        lo_r[i]  <= {loin[COORD_BITS-2:0], 1'b0};
        den_r[i] <= denin;
      end
    end
  end

  assign q_o   = q_r[COORD_BITS-1];
  assign rnz_o = |r_r[COORD_BITS-1];
endmodule
`default_nettype wire

FILE: rtl/point_near_segment_hit_test.sv
// top level of the point-near-segment hit test pipeline
// depends on pnsh_pkg and pnsh_div
//
// Takes one transfer per cycle unless the pipe holds, and returns one result
// per item, in order. Six arithmetic stages form the differences, products,
// dot/length/cross sums and the tolerance compare; COORD_BITS divider stages,
// one quotient bit each, give the foot coordinates; a final register holds
// the result. The whole pipe holds while a result waits at the output, so
// in_tready is high only while the output is empty or out_tready is high.
// Vertical and horizontal segments take an inclusive span test and an
// absolute-difference distance test. tolerance resets to 2 and should be
// written only while the pipe is empty.
`default_nettype none
module point_near_segment_hit_test (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pnsh_pkg::TOL_BITS-1:0] cfg_wr_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // point_x, point_y, begin_x, begin_y, end_x, end_y
  input  wire logic [pnsh_pkg::IN_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // foot_x, foot_y
  output logic      [pnsh_pkg::OUT_W-1:0]    out_tdata,
  // hit
  output logic                               out_tuser
);
  import pnsh_pkg::*;

  localparam int N = COORD_BITS;

  typedef struct packed {
    logic                spec;
    logic                spec_hit;
    logic signed [N-1:0] sfx;
    logic signed [N-1:0] sfy;
    logic signed [N-1:0] x1;
    logic signed [N-1:0] y1;
    logic                dxneg;
    logic                dyneg;
  } side_t;

  logic                 adv;
  logic [TOL_BITS-1:0]  tol_r;
  logic [TOL2_W-1:0]    tol2_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_BITS'(2);
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    tol2_r <= TOL2_W'(tol_r) * TOL2_W'(tol_r);
  end

  // stage a: differences and the axis-aligned cases
  logic signed [N-1:0] xp, yp, x1, y1, x2, y2;
  logic signed [DIFF_W-1:0] dxa, dya, vxa, vya, ex, ey;
  logic [DIFF_W-1:0] aex, aey;
  logic vert, horiz, vhit, hhit;
  side_t sa;

  always_comb begin
    xp  = $signed(in_tdata[0*N +: N]);
    yp  = $signed(in_tdata[1*N +: N]);
    x1  = $signed(in_tdata[2*N +: N]);
    y1  = $signed(in_tdata[3*N +: N]);
    x2  = $signed(in_tdata[4*N +: N]);
    y2  = $signed(in_tdata[5*N +: N]);
    dxa = DIFF_W'(x2) - DIFF_W'(x1);
    dya = DIFF_W'(y2) - DIFF_W'(y1);
    vxa = DIFF_W'(xp) - DIFF_W'(x1);
    vya = DIFF_W'(yp) - DIFF_W'(y1);
    ex  = DIFF_W'(x1) - DIFF_W'(xp);
    ey  = DIFF_W'(y1) - DIFF_W'(yp);
    aex = ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
    aey = ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
    vert  = (x1 == x2);
    horiz = (y1 == y2);
    vhit = ((y1 <= yp && yp <= y2) || (y1 >= yp && yp >= y2)) &&
           ((DIFF_W + TOL_BITS)'(aex) <= (DIFF_W + TOL_BITS)'(tol_r));
    hhit = ((x1 <= xp && xp <= x2) || (x1 >= xp && xp >= x2)) &&
           ((DIFF_W + TOL_BITS)'(aey) <= (DIFF_W + TOL_BITS)'(tol_r));
    sa.spec     = vert || horiz;
    sa.spec_hit = vert ? vhit : hhit;
    sa.sfx      = vert ? x1 : xp;
    sa.sfy      = vert ? yp : y1;
    sa.x1       = x1;
    sa.y1       = y1;
    sa.dxneg    = dxa[DIFF_W-1];
    sa.dyneg    = dya[DIFF_W-1];
  end

  logic a_v_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r, a_vx_r, a_vy_r;
  side_t a_s_r;

  // stage b: products
  logic b_v_r;
  logic signed [PROD_W-1:0] b_vxdx_r, b_vydy_r, b_dxdx_r, b_dydy_r, b_vxdy_r, b_vydx_r;
  logic [N-1:0] b_adx_r, b_ady_r;
  side_t b_s_r;

  // stage c: dot, squared length, cross magnitude
  logic c_v_r;
  logic signed [SUM_W-1:0] dot_c, cross_c;
  logic signed [SUM_W-1:0] c_dot_r;
  logic [LEN_W-1:0] c_len2_r;
  logic [AC_W-1:0] c_ac_r;
  logic [N-1:0] c_adx_r, c_ady_r;
  side_t c_s_r;

  // stage d: partial squares, tolerance product, numerators
  logic d_v_r;
  logic [2*AH_W-1:0] d_hh_r;
  logic [AH_W+AL_W-1:0] d_hl_r;
  logic [2*AL_W-1:0] d_ll_r;
  logic [TL_W-1:0] d_tl_r;
  logic [NUM_W-1:0] d_numx_r, d_numy_r;
  logic [LEN_W-1:0] d_len2_r;
  logic d_dok_r;
  logic dok_c;
  logic [LEN_W-1:0] dotu_c;
  side_t d_s_r;

  // stage e: cross squared
  logic e_v_r;
  logic [SQ_W-1:0] e_sq_r;
  logic [TL_W-1:0] e_tl_r;
  logic [NUM_W-1:0] e_numx_r, e_numy_r;
  logic [LEN_W-1:0] e_len2_r;
  logic e_dok_r;
  side_t e_s_r;

  // stage f: distance compare, divider feed
  logic f_v_r;
  logic f_hit_r;
  logic [NUM_W-1:0] f_numx_r, f_numy_r;
  logic [LEN_W-1:0] f_len2_r;
  side_t f_s_r;

  always_comb begin
    dot_c   = SUM_W'(b_vxdx_r) + SUM_W'(b_vydy_r);
    cross_c = SUM_W'(b_vxdy_r) - SUM_W'(b_vydx_r);
    dok_c   = !c_dot_r[SUM_W-1] && ($unsigned(c_dot_r) <= SUM_W'(c_len2_r));
    dotu_c  = LEN_W'($unsigned(c_dot_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx_r   <= dxa;
      a_dy_r   <= dya;
      a_vx_r   <= vxa;
      a_vy_r   <= vya;
      a_s_r    <= sa;

      b_vxdx_r <= PROD_W'(a_vx_r) * PROD_W'(a_dx_r);
      b_vydy_r <= PROD_W'(a_vy_r) * PROD_W'(a_dy_r);
      b_dxdx_r <= PROD_W'(a_dx_r) * PROD_W'(a_dx_r);
      b_dydy_r <= PROD_W'(a_dy_r) * PROD_W'(a_dy_r);
      b_vxdy_r <= PROD_W'(a_vx_r) * PROD_W'(a_dy_r);
      b_vydx_r <= PROD_W'(a_vy_r) * PROD_W'(a_dx_r);
      b_adx_r  <= a_dx_r[DIFF_W-1] ? N'(-a_dx_r) : N'(a_dx_r);
      b_ady_r  <= a_dy_r[DIFF_W-1] ? N'(-a_dy_r) : N'(a_dy_r);
      b_s_r    <= a_s_r;

      c_dot_r  <= dot_c;
      c_len2_r <= LEN_W'($unsigned(b_dxdx_r)) + LEN_W'($unsigned(b_dydy_r));
      c_ac_r   <= cross_c[SUM_W-1] ? AC_W'(-cross_c) : AC_W'(cross_c);
      c_adx_r  <= b_adx_r;
      c_ady_r  <= b_ady_r;
      c_s_r    <= b_s_r;

      d_hh_r   <= (2*AH_W)'(c_ac_r[AC_W-1 -: AH_W]) * (2*AH_W)'(c_ac_r[AC_W-1 -: AH_W]);
      d_hl_r   <= (AH_W+AL_W)'(c_ac_r[AC_W-1 -: AH_W]) * (AH_W+AL_W)'(c_ac_r[AL_W-1:0]);
      d_ll_r   <= (2*AL_W)'(c_ac_r[AL_W-1:0]) * (2*AL_W)'(c_ac_r[AL_W-1:0]);
      d_tl_r   <= TL_W'(tol2_r) * TL_W'(c_len2_r);
      d_numx_r <= NUM_W'(c_adx_r) * NUM_W'(dotu_c);
      d_numy_r <= NUM_W'(c_ady_r) * NUM_W'(dotu_c);
      d_len2_r <= c_len2_r;
      d_dok_r  <= dok_c;
      d_s_r    <= c_s_r;

      e_sq_r   <= (SQ_W'(d_hh_r) << (2*AL_W)) + (SQ_W'(d_hl_r) << (AL_W+1)) +
                  SQ_W'(d_ll_r);
      e_tl_r   <= d_tl_r;
      e_numx_r <= d_numx_r;
      e_numy_r <= d_numy_r;
      e_len2_r <= d_len2_r;
      e_dok_r  <= d_dok_r;
      e_s_r    <= d_s_r;

      f_hit_r  <= e_dok_r && (CMP_W'(e_sq_r) <= CMP_W'(e_tl_r));
      f_numx_r <= e_numx_r;
      f_numy_r <= e_numy_r;
      f_len2_r <= e_len2_r;
      f_s_r    <= e_s_r;
    end
  end

  // foot division, both coordinates side by side
  logic [N-1:0] qx, qy;
  logic rnzx, rnzy;

  pnsh_div u_div_x (
    .clk   (clk),
    .en    (adv),
    .num_i (f_numx_r),
    .den_i (f_len2_r),
    .q_o   (qx),
    .rnz_o (rnzx)
  );

  pnsh_div u_div_y (
    .clk   (clk),
    .en    (adv),
    .num_i (f_numy_r),
    .den_i (f_len2_r),
    .q_o   (qy),
    .rnz_o (rnzy)
  );

  // side data travels alongside the divider stages
  logic  dl_v_r   [N];
  logic  dl_hit_r [N];
  side_t dl_s_r   [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        dl_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      dl_v_r[0] <= f_v_r;
      for (int i = 1; i < N; i++) begin
        dl_v_r[i] <= dl_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_hit_r[0] <= f_hit_r;
      dl_s_r[0]   <= f_s_r;
      for (int i = 1; i < N; i++) begin
        dl_hit_r[i] <= dl_hit_r[i-1];
        dl_s_r[i]   <= dl_s_r[i-1];
      end
    end
  end

  // truncate toward zero after base +/- quotient
  side_t sg;
  logic signed [FOOT_W-1:0] flx, fly, fox, foy;
  logic hit_g;
  logic [N-1:0] fx_g, fy_g;

  always_comb begin
    sg  = dl_s_r[N-1];
    flx = sg.dxneg ? (FOOT_W'(sg.x1) - $signed(FOOT_W'(qx)) - $signed(FOOT_W'(rnzx)))
                   : (FOOT_W'(sg.x1) + $signed(FOOT_W'(qx)));
    fly = sg.dyneg ? (FOOT_W'(sg.y1) - $signed(FOOT_W'(qy)) - $signed(FOOT_W'(rnzy)))
                   : (FOOT_W'(sg.y1) + $signed(FOOT_W'(qy)));
    fox = flx + $signed(FOOT_W'(rnzx && flx[FOOT_W-1]));
    foy = fly + $signed(FOOT_W'(rnzy && fly[FOOT_W-1]));
    hit_g = sg.spec ? sg.spec_hit : dl_hit_r[N-1];
    fx_g  = !hit_g ? '0 : (sg.spec ? sg.sfx : fox[N-1:0]);
    fy_g  = !hit_g ? '0 : (sg.spec ? sg.sfy : foy[N-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= dl_v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tuser <= hit_g;
      out_tdata <= OUT_W'({fy_g, fx_g});
    end
  end
endmodule
`default_nettype wire
